// ----- sv/pic_pkg.sv -----
// Shared types and constants of the platform interrupt controller.
package pic_pkg;

    // Stream payload widths (bytes rounded up)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 48;

    localparam int ADDR_W      = 26;
    localparam int DATA_W      = 32;
    localparam int SRC_FIELD_W = 5;
    localparam int CLAIM_W     = 5;

    // Widest decoded index fields: ids up to 1023, words up to 31, contexts up to 15
    localparam int ID_FIELD_W   = 10;
    localparam int WORD_FIELD_W = 5;
    localparam int CTX_FIELD_W  = 4;

    // 4 KiB pages of the register map (address bits 25:12)
    localparam logic [13:0] PAGE_PRIO     = 14'h000;
    localparam logic [13:0] PAGE_PEND     = 14'h001;
    localparam logic [13:0] PAGE_ENAB     = 14'h002;
    localparam logic [13:0] CTX_PAGE_BASE = 14'h200;

    // Word offsets inside a context page
    localparam logic [9:0] OFF_THRESHOLD = 10'd0;
    localparam logic [9:0] OFF_CLAIM     = 10'd1;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_RAISE = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_ZERO,
        ACC_PRIO,
        ACC_PEND,
        ACC_ENAB,
        ACC_THR,
        ACC_CLAIM,
        ACC_RAISE
    } acc_kind_t;

    typedef struct packed {
        acc_kind_t                kind;
        logic                     bad;
        logic                     wr;
        logic [ID_FIELD_W-1:0]    id;
        logic [WORD_FIELD_W-1:0]  word;
        logic [CTX_FIELD_W-1:0]   ctx;
        logic [SRC_FIELD_W-1:0]   bit_pos;
    } acc_dec_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } scan_ctl_t;

endpackage

// ----- sv/pic_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
module pic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/pic_decode.sv -----
// Address and command decoder for bus accesses and source raises.
module pic_decode #(
    parameter int NUM_SOURCES  = 32,
    parameter int NUM_CONTEXTS = 2
) (
    input  logic [1:0]                     command,
    input  logic [pic_pkg::ADDR_W-1:0]     address,
    input  logic [pic_pkg::SRC_FIELD_W-1:0] source_id,
    output pic_pkg::acc_dec_t              dec
);

    localparam int NUM_WORDS = (NUM_SOURCES + 31) / 32;

    logic [13:0] page;
    logic [9:0]  word_off;
    logic [13:0] ctx_page;

    assign page     = address[25:12];
    assign word_off = address[11:2];
    assign ctx_page = page - pic_pkg::CTX_PAGE_BASE;

    always_comb
    begin
        dec         = '0;
        dec.kind    = pic_pkg::ACC_NONE;
        dec.wr      = (command == pic_pkg::CMD_WRITE);
        case (command)
            pic_pkg::CMD_READ, pic_pkg::CMD_WRITE:
            begin
                if (page == pic_pkg::PAGE_PRIO)
                begin
                    if ({1'b0, word_off} >= 11'(NUM_SOURCES))
                    begin
                        dec.bad = 1'b1;
                    end
                    else if (word_off == 10'd0)
                    begin
                        dec.kind = pic_pkg::ACC_ZERO;
                    end
                    else
                    begin
                        dec.kind = pic_pkg::ACC_PRIO;
                        dec.id   = word_off;
                        dec.word = word_off[9:5];
                    end
                end
                else if (page == pic_pkg::PAGE_PEND)
                begin
                    if ({1'b0, word_off} < 11'(NUM_WORDS))
                    begin
                        dec.kind = pic_pkg::ACC_PEND;
                        dec.word = word_off[4:0];
                    end
                    else
                    begin
                        dec.bad = 1'b1;
                    end
                end
                else if (page == pic_pkg::PAGE_ENAB)
                begin
                    // context in bits 11:7, word in bits 6:2
                    if ((6'(address[11:7]) < 6'(NUM_CONTEXTS)) &&
                        (6'(address[6:2]) < 6'(NUM_WORDS)))
                    begin
                        dec.kind = pic_pkg::ACC_ENAB;
                        dec.ctx  = address[10:7];
                        dec.word = address[6:2];
                    end
                    else
                    begin
                        dec.bad = 1'b1;
                    end
                end
                else if (address[25:21] != 5'd0)
                begin
                    if (ctx_page < 14'(NUM_CONTEXTS))
                    begin
                        dec.ctx = ctx_page[3:0];
                        if (word_off == pic_pkg::OFF_THRESHOLD)
                        begin
                            dec.kind = pic_pkg::ACC_THR;
                        end
                        else if (word_off == pic_pkg::OFF_CLAIM)
                        begin
                            dec.kind = pic_pkg::ACC_CLAIM;
                        end
                        else
                        begin
                            dec.bad = 1'b1;
                        end
                    end
                    else
                    begin
                        dec.bad = 1'b1;
                    end
                end
                else
                begin
                    dec.bad = 1'b1;
                end
            end
            pic_pkg::CMD_RAISE:
            begin
                if ((source_id != 5'd0) && (11'(source_id) < 11'(NUM_SOURCES)))
                begin
                    dec.kind    = pic_pkg::ACC_RAISE;
                    dec.bit_pos = source_id;
                end
            end
            default:
            begin
                dec.kind = pic_pkg::ACC_NONE;
            end
        endcase
    end

endmodule

// ----- sv/pic_select.sv -----
// Per-context running best-source selection fed by the memory scan.
module pic_select #(
    parameter int NUM_CONTEXTS  = 2,
    parameter int SRC_W         = 5,
    parameter int PRIORITY_BITS = 3
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  pic_pkg::scan_ctl_t                           ctl,
    input  logic [SRC_W-1:0]                             id,
    input  logic [PRIORITY_BITS-1:0]                     prio,
    input  logic [NUM_CONTEXTS:0][31:0]                  row,
    input  logic [NUM_CONTEXTS-1:0][PRIORITY_BITS-1:0]   thr,
    output logic [NUM_CONTEXTS-1:0][SRC_W-1:0]           best
);

    logic [NUM_CONTEXTS-1:0][SRC_W-1:0]         best_reg;
    logic [NUM_CONTEXTS-1:0][PRIORITY_BITS-1:0] best_p_reg;
    logic [NUM_CONTEXTS-1:0]                    take;
    logic [4:0]                                 bit_sel;

    assign bit_sel = 5'(id);

    always_comb
    begin
        for (int c = 0; c < NUM_CONTEXTS; c++)
        begin
            // strict > keeps the lowest id on equal priority
            take[c] = ctl.valid && row[0][bit_sel] && row[c + 1][bit_sel] &&
                      (prio > thr[c]) &&
                      ((best_reg[c] == '0) || (prio > best_p_reg[c]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg   <= '0;
            best_p_reg <= '0;
        end
        else if (ctl.clear)
        begin
            best_reg   <= '0;
            best_p_reg <= '0;
        end
        else
        begin
            for (int c = 0; c < NUM_CONTEXTS; c++)
            begin
                if (take[c])
                begin
                    best_reg[c]   <= id;
                    best_p_reg[c] <= prio;
                end
            end
        end
    end

    assign best = best_reg;

endmodule

// ----- sv/platform_interrupt_controller_top.sv -----
// Platform interrupt controller top level: FSM, register file access and scan control.
//
// Usage: one transaction on the s_axis side is a bus read, a bus write or a source
// raise; each yields exactly one transaction on the m_axis side with the read word,
// the bad-address flag and the claim and interrupt flag of contexts 0 and 1.
// Priorities live in one RAM (one entry per source); pending and enable words share
// a second RAM, one row per 32-source word holding the pending word and all context
// enable words. Thresholds and claims are flip-flops.
// Per item: ACCESS reads the addressed row, MODIFY writes it back, then SCAN steps
// through sources 1..NUM_SOURCES-1, one per cycle through both RAM read ports,
// then DRAIN and FINISH, which loads the output register. A new item is accepted
// only in IDLE, after the previous one has left FINISH; while m_axis does not
// stall, the scan length sets the rate.
// After reset the block clears both RAMs, one entry per cycle, in ST_CLEAR with
// s_axis_tready low. A result waiting on a stalled m_axis is held in
// the output register while the next item is accepted and processed; the block
// holds its finished result until the output register frees up.
module platform_interrupt_controller_top #(
    parameter int NUM_SOURCES   = 32,
    parameter int NUM_CONTEXTS  = 2,
    parameter int PRIORITY_BITS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // command[1:0], address[27:2], write_data[59:28], source_id[64:60], zero fill
    input  logic [pic_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // read_data[31:0], bad_address[32], claim_machine[37:33],
    // claim_supervisor[42:38], irq_machine[43], irq_supervisor[44], zero fill
    output logic [pic_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int NUM_WORDS = (NUM_SOURCES + 31) / 32;
    localparam int SRC_W     = $clog2(NUM_SOURCES);
    localparam int WORD_W    = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
    localparam int CTX_W     = NUM_CONTEXTS > 1 ? $clog2(NUM_CONTEXTS) : 1;
    localparam int ROW_W     = 32 * (NUM_CONTEXTS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_MODIFY,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                                     state_reg;
    pic_pkg::acc_dec_t                          dec;
    pic_pkg::acc_dec_t                          dec_reg;
    logic [31:0]                                wdata_reg;
    logic [SRC_W-1:0]                           clr_cnt_reg;
    logic [SRC_W-1:0]                           scan_id_reg;
    logic [SRC_W-1:0]                           scan_did_reg;
    logic                                       scan_vld_reg;
    logic [31:0]                                rd_data_reg;
    logic [NUM_CONTEXTS-1:0][PRIORITY_BITS-1:0] thr_reg;
    logic [NUM_CONTEXTS-1:0][SRC_W-1:0]         claim_reg;
    logic                                       m_valid_reg;
    logic [pic_pkg::M_TDATA_W-1:0]              m_data_reg;

    // memory ports
    logic                       prio_we;
    logic [SRC_W-1:0]           prio_waddr;
    logic [PRIORITY_BITS-1:0]   prio_wdata;
    logic [SRC_W-1:0]           prio_raddr;
    logic [PRIORITY_BITS-1:0]   prio_q;
    logic                       row_we;
    logic [WORD_W-1:0]          row_waddr;
    logic [NUM_CONTEXTS:0][31:0] row_wdata;
    logic [WORD_W-1:0]          row_raddr;
    logic [NUM_CONTEXTS:0][31:0] row_q;

    logic [CTX_W-1:0]           ctx_i;
    logic [CTX_W:0]             slot;
    logic [31:0]                mask;
    logic [31:0]                rd_comb;
    pic_pkg::scan_ctl_t         scan_ctl;
    logic [NUM_CONTEXTS-1:0][SRC_W-1:0] best;
    logic [SRC_W-1:0]           best0;
    logic [SRC_W-1:0]           best1;
    logic                       out_free;

    // bits of word w that belong to real sources
    function automatic logic [31:0] word_mask(input logic [4:0] w);
        logic [31:0] m;
        logic [10:0] id;
        m = '0;
        for (int b = 0; b < 32; b++)
        begin
            id   = {1'b0, w, 5'(b)};
            m[b] = (id != 11'd0) && (id < 11'(NUM_SOURCES));
        end
        return m;
    endfunction

    pic_decode #(
        .NUM_SOURCES  (NUM_SOURCES),
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_decode (
        .command   (s_axis_tdata[1:0]),
        .address   (s_axis_tdata[27:2]),
        .source_id (s_axis_tdata[64:60]),
        .dec       (dec)
    );

    pic_ram #(
        .WIDTH (PRIORITY_BITS),
        .DEPTH (NUM_SOURCES)
    ) u_prio_ram (
        .clk   (clk),
        .we    (prio_we),
        .waddr (prio_waddr),
        .wdata (prio_wdata),
        .raddr (prio_raddr),
        .rdata (prio_q)
    );

    pic_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_WORDS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (row_raddr),
        .rdata (row_q)
    );

    assign scan_ctl.clear = (state_reg == ST_MODIFY);
    assign scan_ctl.valid = scan_vld_reg;

    pic_select #(
        .NUM_CONTEXTS  (NUM_CONTEXTS),
        .SRC_W         (SRC_W),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_select (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .id    (scan_did_reg),
        .prio  (prio_q),
        .row   (row_q),
        .thr   (thr_reg),
        .best  (best)
    );

    assign ctx_i = dec_reg.ctx[CTX_W-1:0];
    assign slot  = (CTX_W + 1)'(ctx_i) + 1'b1;
    assign mask  = word_mask(dec_reg.word);

    // memory port steering; the scan starts only after the write-back edge,
    // so no forwarding is needed
    always_comb
    begin
        prio_we    = 1'b0;
        prio_waddr = dec_reg.id[SRC_W-1:0];
        prio_wdata = wdata_reg[PRIORITY_BITS-1:0];
        prio_raddr = scan_id_reg;
        row_we     = 1'b0;
        row_waddr  = dec_reg.word[WORD_W-1:0];
        row_wdata  = row_q;
        row_raddr  = WORD_W'(scan_id_reg >> 5);
        case (state_reg)
            ST_CLEAR:
            begin
                prio_we    = 1'b1;
                prio_waddr = clr_cnt_reg;
                prio_wdata = '0;
                row_we     = ({1'b0, clr_cnt_reg} < (SRC_W + 1)'(NUM_WORDS));
                row_waddr  = WORD_W'(clr_cnt_reg);
                row_wdata  = '0;
            end
            ST_ACCESS:
            begin
                prio_raddr = dec_reg.id[SRC_W-1:0];
                row_raddr  = dec_reg.word[WORD_W-1:0];
            end
            ST_MODIFY:
            begin
                prio_we = (dec_reg.kind == pic_pkg::ACC_PRIO) && dec_reg.wr;
                case (dec_reg.kind)
                    pic_pkg::ACC_PEND:
                    begin
                        row_we       = dec_reg.wr;
                        row_wdata[0] = wdata_reg & mask;
                    end
                    pic_pkg::ACC_ENAB:
                    begin
                        row_we          = dec_reg.wr;
                        row_wdata[slot] = wdata_reg & mask;
                    end
                    pic_pkg::ACC_RAISE:
                    begin
                        row_we                        = 1'b1;
                        row_wdata[0][dec_reg.bit_pos] = 1'b1;
                    end
                    default:
                    begin
                        row_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                prio_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (dec_reg.kind)
            pic_pkg::ACC_PRIO:  rd_comb = 32'(prio_q);
            pic_pkg::ACC_PEND:  rd_comb = row_q[0];
            pic_pkg::ACC_ENAB:  rd_comb = row_q[slot];
            pic_pkg::ACC_THR:   rd_comb = 32'(thr_reg[ctx_i]);
            pic_pkg::ACC_CLAIM: rd_comb = 32'(claim_reg[ctx_i]);
            default:            rd_comb = '0;
        endcase
        if (dec_reg.wr)
        begin
            rd_comb = '0;
        end
    end

    assign best0    = best[0];
    assign best1    = (NUM_CONTEXTS > 1) ? best[NUM_CONTEXTS > 1 ? 1 : 0] : '0;
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            dec_reg      <= '0;
            wdata_reg    <= '0;
            clr_cnt_reg  <= '0;
            scan_id_reg  <= '0;
            scan_did_reg <= '0;
            scan_vld_reg <= 1'b0;
            rd_data_reg  <= '0;
            thr_reg      <= '0;
            claim_reg    <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            scan_vld_reg <= (state_reg == ST_SCAN);
            // in finish, a free output register is refilled below instead
            if (m_valid_reg && m_axis_tready && (state_reg != ST_FINISH))
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == SRC_W'(NUM_SOURCES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        dec_reg   <= dec;
                        wdata_reg <= s_axis_tdata[59:28];
                        state_reg <= ST_ACCESS;
                    end
                end
                ST_ACCESS:
                begin
                    state_reg <= ST_MODIFY;
                end
                ST_MODIFY:
                begin
                    rd_data_reg <= rd_comb;
                    if ((dec_reg.kind == pic_pkg::ACC_THR) && dec_reg.wr)
                    begin
                        thr_reg[ctx_i] <= wdata_reg[PRIORITY_BITS-1:0];
                    end
                    scan_id_reg <= SRC_W'(1);
                    state_reg   <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    scan_did_reg <= scan_id_reg;
                    if (scan_id_reg == SRC_W'(NUM_SOURCES - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        scan_id_reg <= scan_id_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        claim_reg   <= best;
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'b000,
                                        (best1 != '0),
                                        (best0 != '0),
                                        5'(best1),
                                        5'(best0),
                                        dec_reg.bad,
                                        rd_data_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // an accepted transaction always starts the row read
    a_accept_to_access: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_ACCESS))
        else $error("accepted transaction did not start an access");

    // no RAM write while the scan reads it
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN) |-> (!prio_we && !row_we))
        else $error("RAM written during scan");

    // a new result only follows a completed scan
    a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !$past(m_valid_reg)) |-> ($past(state_reg) == ST_FINISH))
        else $error("result raised outside finish");

    // the claim of context 0 only names existing sources
    a_claim_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, claim_reg[0]} < (SRC_W + 1)'(NUM_SOURCES)))
        else $error("claim beyond source count");

endmodule
